// ===== hdl/ir90_pkg.sv =====
// ir90_pkg: shared constants for the 90 degree image rotation block
// frame store geometry, configuration register indexes, port widths
// no dependencies
package ir90_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // column and row counters, and clamped dimensions that can hold the maximum
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

    // register interface
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // input item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam int PIXEL_W  = 24;
    localparam int S_USER_W = 1;
    localparam int M_USER_W = 4;

endpackage

// ===== hdl/image_rotate_90_unit.sv =====
// image_rotate_90_unit: rotates a 24-bit frame by 90 degrees through a frame store
// depends on ir90_pkg for geometry, register indexes and port widths
//
// usage
//   s_ channel: one word per item. s_tuser[0] is the mode: load writes the pixel
//   in s_tdata into the frame store in row order; read asks for the next pixel of
//   the rotated image. load words give no result, every read word gives one.
//   m_ channel: one result word per read. m_tuser[0] says whether a pixel is
//   delivered (0 before the frame is full or after its last pixel, then all
//   other fields are zero). m_tlast marks the last pixel of an output row, with
//   the pad byte count beside it; m_tuser[3] marks the last pixel of the frame.
//   cfg_ channel: width (index 0), height (index 1); the user writes them only while idle,
//   not enforced by the block; width/height writes restart the frame, unknown indexes are ignored.
// pipeline and throughput
//   one word per cycle on both sides while m_tready is high. a read is issued to the
//   store in the cycle it is accepted, the store answers into store_rd_reg in the next
//   cycle, and the result moves on into the output register once that register is free.
//   the figure is set by the single store port: one access per cycle.
// reset and stall
//   reset clears positions, frame flag and both pipeline slots; the store holds
//   no meaning until loaded, so it is not cleared. a stalled receiver holds the
//   output word, one more read can wait in the store read slot, then s_tready drops.
module image_rotate_90_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ir90_pkg::PIXEL_W-1:0]          s_tdata,   // blue_in, green_in, red_in
    input  logic [ir90_pkg::S_USER_W-1:0]         s_tuser,   // mode
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ir90_pkg::PIXEL_W-1:0]          m_tdata,   // blue_out, green_out, red_out
    output logic                                  m_tlast,   // row_end
    output logic [ir90_pkg::M_USER_W-1:0]         m_tuser,   // valid_res, pad_after[1:0], frame_end
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ir90_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ir90_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // frame store, one pixel per entry, row-major with a fixed row pitch
    logic [ir90_pkg::PIXEL_W-1:0] store_mem [ir90_pkg::STORE_DEPTH];
    logic [ir90_pkg::PIXEL_W-1:0] store_rd_reg;

    // clamped dimensions
    logic [ir90_pkg::WDIM_W-1:0] width_reg,  width_next;
    logic [ir90_pkg::HDIM_W-1:0] height_reg, height_next;

    // load and read positions
    logic [ir90_pkg::ROW_W-1:0] load_row_reg, load_row_next;
    logic [ir90_pkg::COL_W-1:0] load_col_reg, load_col_next;
    logic                       loaded_reg,   loaded_next;
    logic [ir90_pkg::COL_W-1:0] out_row_reg,  out_row_next;
    logic [ir90_pkg::ROW_W-1:0] out_pos_reg,  out_pos_next;

    // read slot: store access issued, data arrives in store_rd_reg
    logic       pend_reg,       pend_next;
    logic       pend_ok_reg,    pend_ok_next;
    logic       pend_rend_reg,  pend_rend_next;
    logic [1:0] pend_pad_reg,   pend_pad_next;
    logic       pend_fend_reg,  pend_fend_next;

    // output word
    logic                         ov_reg, ov_next;
    logic [ir90_pkg::PIXEL_W-1:0] o_pix_reg;
    logic                         o_ok_reg, o_rend_reg, o_fend_reg;
    logic [1:0]                   o_pad_reg;

    logic                          in_acc, cfg_acc, move;
    logic                          is_load, is_read;
    logic                          wr_en, rd_en;
    logic [ir90_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
    logic [ir90_pkg::COL_W-1:0]    rd_col;
    logic [ir90_pkg::WDIM_W-1:0]   col_inc, row_inc_w;
    logic [ir90_pkg::HDIM_W-1:0]   row_inc_h, pos_inc;
    logic                          rend, fend;

    // the read slot drains whenever the output register is free or being taken
    assign move      = !ov_reg || m_tready;
    assign s_tready  = !pend_reg || move;
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign is_load   = in_acc && (s_tuser[0] == ir90_pkg::MODE_LOAD);
    assign is_read   = in_acc && (s_tuser[0] == ir90_pkg::MODE_READ);

    // load side address and wrap tests
    assign wr_addr   = ir90_pkg::ADDR_W'(load_row_reg) * ir90_pkg::ADDR_W'(ir90_pkg::MAX_WIDTH)
                     + ir90_pkg::ADDR_W'(load_col_reg);
    assign col_inc   = ir90_pkg::WDIM_W'(load_col_reg) + ir90_pkg::WDIM_W'(1);
    assign row_inc_h = ir90_pkg::HDIM_W'(load_row_reg) + ir90_pkg::HDIM_W'(1);
    assign wr_en     = is_load && !loaded_reg;

    // read side: output row r, position i is input row i, column width-1-r
    assign rd_col    = ir90_pkg::COL_W'(width_reg - ir90_pkg::WDIM_W'(1)
                                        - ir90_pkg::WDIM_W'(out_row_reg));
    assign rd_addr   = ir90_pkg::ADDR_W'(out_pos_reg) * ir90_pkg::ADDR_W'(ir90_pkg::MAX_WIDTH)
                     + ir90_pkg::ADDR_W'(rd_col);
    assign pos_inc   = ir90_pkg::HDIM_W'(out_pos_reg) + ir90_pkg::HDIM_W'(1);
    assign row_inc_w = ir90_pkg::WDIM_W'(out_row_reg) + ir90_pkg::WDIM_W'(1);
    assign rend      = (pos_inc == height_reg);
    assign fend      = rend && (row_inc_w == width_reg);
    assign rd_en     = is_read && loaded_reg;

    always_comb begin
        width_next     = width_reg;
        height_next    = height_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        loaded_next    = loaded_reg;
        out_row_next   = out_row_reg;
        out_pos_next   = out_pos_reg;
        pend_next      = pend_reg;
        pend_ok_next   = pend_ok_reg;
        pend_rend_next = pend_rend_reg;
        pend_pad_next  = pend_pad_reg;
        pend_fend_next = pend_fend_reg;
        ov_next        = ov_reg;

        // output register and read slot
        if (move) begin
            ov_next   = pend_reg;
            pend_next = 1'b0;
        end
        if (is_read) begin
            pend_next      = 1'b1;
            pend_ok_next   = loaded_reg;
            pend_rend_next = loaded_reg && rend;
            // (4 - 3h mod 4) mod 4 reduces to h mod 4
            pend_pad_next  = (loaded_reg && rend) ? height_reg[1:0] : 2'd0;
            pend_fend_next = loaded_reg && fend;
        end

        // load position
        if (wr_en) begin
            if (col_inc == width_reg) begin
                load_col_next = '0;
                if (row_inc_h == height_reg) begin
                    load_row_next = '0;
                    loaded_next   = 1'b1;
                end else begin
                    load_row_next = ir90_pkg::ROW_W'(row_inc_h);
                end
            end else begin
                load_col_next = ir90_pkg::COL_W'(col_inc);
            end
        end

        // read position, last pixel frees the store for a new frame
        if (rd_en) begin
            if (fend) begin
                out_row_next = '0;
                out_pos_next = '0;
                loaded_next  = 1'b0;
            end else if (rend) begin
                out_pos_next = '0;
                out_row_next = ir90_pkg::COL_W'(row_inc_w);
            end else begin
                out_pos_next = ir90_pkg::ROW_W'(pos_inc);
            end
        end

        // register writes clamp and restart the frame
        if (cfg_acc && (cfg_index == ir90_pkg::CFG_IMAGE_WIDTH ||
                        cfg_index == ir90_pkg::CFG_IMAGE_HEIGHT)) begin
            if (cfg_index == ir90_pkg::CFG_IMAGE_WIDTH) begin
                if (cfg_data == '0) begin
                    width_next = ir90_pkg::WDIM_W'(1);
                end else if (32'(cfg_data) > 32'(ir90_pkg::MAX_WIDTH)) begin
                    width_next = ir90_pkg::WDIM_W'(ir90_pkg::MAX_WIDTH);
                end else begin
                    width_next = ir90_pkg::WDIM_W'(cfg_data);
                end
            end else begin
                if (cfg_data == '0) begin
                    height_next = ir90_pkg::HDIM_W'(1);
                end else if (32'(cfg_data) > 32'(ir90_pkg::MAX_HEIGHT)) begin
                    height_next = ir90_pkg::HDIM_W'(ir90_pkg::MAX_HEIGHT);
                end else begin
                    height_next = ir90_pkg::HDIM_W'(cfg_data);
                end
            end
            load_row_next = '0;
            load_col_next = '0;
            loaded_next   = 1'b0;
            out_row_next  = '0;
            out_pos_next  = '0;
        end
    end

    // frame store port: one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= s_tdata;
        end
        if (rd_en) begin
            store_rd_reg <= store_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= ir90_pkg::WDIM_W'(1);
            height_reg   <= ir90_pkg::HDIM_W'(1);
            load_row_reg <= '0;
            load_col_reg <= '0;
            loaded_reg   <= 1'b0;
            out_row_reg  <= '0;
            out_pos_reg  <= '0;
            pend_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            loaded_reg   <= loaded_next;
            out_row_reg  <= out_row_next;
            out_pos_reg  <= out_pos_next;
            pend_reg     <= pend_next;
            ov_reg       <= ov_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pend_ok_reg   <= pend_ok_next;
        pend_rend_reg <= pend_rend_next;
        pend_pad_reg  <= pend_pad_next;
        pend_fend_reg <= pend_fend_next;
        if (move && pend_reg) begin
            // a read that found no frame gives an all-zero pixel
            o_pix_reg  <= pend_ok_reg ? store_rd_reg : '0;
            o_ok_reg   <= pend_ok_reg;
            o_rend_reg <= pend_rend_reg;
            o_pad_reg  <= pend_pad_reg;
            o_fend_reg <= pend_fend_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = o_pix_reg;
    assign m_tlast  = o_rend_reg;
    assign m_tuser  = {o_fend_reg, o_pad_reg, o_ok_reg};

endmodule

// ===== hdl/image_rotate_90_unit_checker.sv =====
// image_rotate_90_unit_checker: port-level assertions for the rotation block
// depends on ir90_pkg for port widths; bound to image_rotate_90_unit below
module image_rotate_90_unit_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ir90_pkg::PIXEL_W-1:0]  m_tdata,
    input logic                          m_tlast,
    input logic [ir90_pkg::M_USER_W-1:0] m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a word with no pixel carries nothing else
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tlast && m_tuser[3:1] == 3'd0)
        else $error("empty result word carries data");

    // frame end is always also a row end
    a_fend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tlast && m_tuser[0])
        else $error("frame end without row end");

    // padding only at row ends
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
        else $error("pad bytes away from row end");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind image_rotate_90_unit image_rotate_90_unit_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for image_rotate_90_unit
// drives load and read words, writes geometry registers, compares every result word
// against an in-bench rotation model; depends on ir90_pkg and the rtl only
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_PERCENT   = 7;
    localparam int RANDOM_WORDS   = 200;
    localparam int LINE_READS     = 3;
    // indexes with no register behind them, the block must ignore them
    localparam logic [ir90_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [ir90_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic       valid_res;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic [1:0] pad_after;
        logic       frame_end;
    } rotated_pixel_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ir90_pkg::PIXEL_W-1:0]    s_tdata = '0;      // blue_in, green_in, red_in
    logic [ir90_pkg::S_USER_W-1:0]   s_tuser = '0;      // mode
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ir90_pkg::PIXEL_W-1:0]    m_tdata;           // blue_out, green_out, red_out
    logic                            m_tlast;           // row_end
    logic [ir90_pkg::M_USER_W-1:0]   m_tuser;           // valid_res, pad_after[1:0], frame_end
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ir90_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ir90_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    image_rotate_90_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // rotation model state: raw register values, load and read positions, frame store
    logic [ir90_pkg::CFG_DATA_W-1:0] img_width_reg  = 9'd1;
    logic [ir90_pkg::CFG_DATA_W-1:0] img_height_reg = 9'd1;
    int unsigned                     load_y, load_x, rd_row, rd_pos;
    bit                              frame_full;
    bit [ir90_pkg::PIXEL_W-1:0]      frame_pix [ir90_pkg::STORE_DEPTH];
    rotated_pixel_t                  rotated_q [$];
    rotated_pixel_t                  exp_px;

    int unsigned mismatch_count, pixels_checked, frames_read, reg_writes, stall_cycles;
    bit          no_stall = 1'b0;

    // a width or height register write drops the frame in flight, as does the last rotated pixel
    function automatic void restart_positions();
        load_y     = 0;
        load_x     = 0;
        rd_row     = 0;
        rd_pos     = 0;
        frame_full = 1'b0;
    endfunction

    // out-of-range register values saturate: zero acts as one, above max acts as max
    function automatic int unsigned clamp_dim(logic [ir90_pkg::CFG_DATA_W-1:0] raw,
                                              int unsigned top);
        if (raw == 0) return 1;
        if (32'(raw) > top) return top;
        return 32'(raw);
    endfunction

    // one accepted input word: a load fills the store in row order, a read
    // produces the next rotated pixel (or an all-zero word when nothing is ready)
    function automatic void rotate_predict(logic mode, logic [ir90_pkg::PIXEL_W-1:0] pix);
        int unsigned    w, h;
        rotated_pixel_t r;
        w = clamp_dim(img_width_reg, ir90_pkg::MAX_WIDTH);
        h = clamp_dim(img_height_reg, ir90_pkg::MAX_HEIGHT);
        if (mode == ir90_pkg::MODE_LOAD) begin
            if (!frame_full) begin
                frame_pix[load_y * ir90_pkg::MAX_WIDTH + load_x] = pix;
                load_x++;
                if (load_x >= w) begin
                    load_x = 0;
                    load_y++;
                    if (load_y >= h) begin
                        load_y     = 0;
                        frame_full = 1'b1;
                    end
                end
            end
            return;
        end
        r = '0;
        if (frame_full) begin
            // output row r, position i comes from input row i, column w-1-r
            r.valid_res = 1'b1;
            {r.red, r.green, r.blue} = frame_pix[rd_pos * ir90_pkg::MAX_WIDTH
                                                 + (w - 1 - rd_row)];
            r.row_end   = (rd_pos + 1 >= h);
            r.frame_end = r.row_end && (rd_row + 1 >= w);
            // zero bytes that keep each output row of h pixels 4-byte aligned
            if (r.row_end) r.pad_after = 2'((4 - (3 * h) % 4) % 4);
            if (r.frame_end) begin
                restart_positions();
                frames_read++;
            end else if (r.row_end) begin
                rd_pos = 0;
                rd_row++;
            end else begin
                rd_pos++;
            end
        end
        rotated_q.push_back(r);
    endfunction

    // input and register words are tracked where they are accepted
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) rotate_predict(s_tuser[0], s_tdata);
        if (aresetn && cfg_valid && cfg_ready) begin
            reg_writes++;
            if (cfg_index == ir90_pkg::CFG_IMAGE_WIDTH) begin
                img_width_reg = cfg_data;
                restart_positions();
            end else if (cfg_index == ir90_pkg::CFG_IMAGE_HEIGHT) begin
                img_height_reg = cfg_data;
                restart_positions();
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // result checker: each accepted result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (rotated_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with nothing expected, expected none, actual %h",
                         $time, {m_tuser, m_tlast, m_tdata});
            end else begin
                exp_px = rotated_q.pop_front();
                pixels_checked++;
                check_field("valid_res", exp_px.valid_res, m_tuser[0]);
                check_field("blue_out",  exp_px.blue,      m_tdata[7:0]);
                check_field("green_out", exp_px.green,     m_tdata[15:8]);
                check_field("red_out",   exp_px.red,       m_tdata[23:16]);
                check_field("row_end",   exp_px.row_end,   m_tlast);
                check_field("pad_after", exp_px.pad_after, m_tuser[2:1]);
                check_field("frame_end", exp_px.frame_end, m_tuser[3]);
            end
        end
    end

    // receiver backpressure, switched off during the no-idle stretches
    always @(negedge aclk) begin
        m_tready <= no_stall || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // watchdog: cycles without any accepted word on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, rotated_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // sends one input word; entered and left at a falling edge, tvalid stays high
    // between back-to-back words so it gets a single assignment per step
    task automatic send_word(input logic mode, input logic [ir90_pkg::PIXEL_W-1:0] pix);
        while (!no_stall && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= mode;
        s_tdata    <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending, let every predicted word arrive, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ir90_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ir90_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // both registers, in random order
    task automatic set_size(input logic [ir90_pkg::CFG_DATA_W-1:0] w,
                            input logic [ir90_pkg::CFG_DATA_W-1:0] h);
        if ($urandom_range(0, 1)) begin
            write_reg(ir90_pkg::CFG_IMAGE_WIDTH, w);
            write_reg(ir90_pkg::CFG_IMAGE_HEIGHT, h);
        end else begin
            write_reg(ir90_pkg::CFG_IMAGE_HEIGHT, h);
            write_reg(ir90_pkg::CFG_IMAGE_WIDTH, w);
        end
    endtask

    // reset geometry is 1x1: read too early, load, ignored load, read, read past the end
    task automatic test_reset_geometry();
        send_word(ir90_pkg::MODE_READ, 24'hffffff);
        send_word(ir90_pkg::MODE_LOAD, 24'hffffff);
        send_word(ir90_pkg::MODE_LOAD, 24'h000000);
        send_word(ir90_pkg::MODE_READ, 24'h000000);
        send_word(ir90_pkg::MODE_READ, 24'h000000);
        drain();
    endtask

    // 3x2 frame with extreme pixel bytes; writes to unused indexes must not abort it
    task automatic test_corner_pixels();
        set_size(9'd3, 9'd2);
        send_word(ir90_pkg::MODE_READ, 24'h000000);
        send_word(ir90_pkg::MODE_LOAD, 24'h000000);
        send_word(ir90_pkg::MODE_LOAD, 24'hffffff);
        send_word(ir90_pkg::MODE_LOAD, 24'h0000ff);
        send_word(ir90_pkg::MODE_LOAD, 24'h00ff00);
        send_word(ir90_pkg::MODE_LOAD, 24'hff0000);
        send_word(ir90_pkg::MODE_LOAD, 24'h5a3cc3);
        send_word(ir90_pkg::MODE_LOAD, 24'h123456);
        drain();
        write_reg(CFG_SPARE_LO, 9'h1ff);
        write_reg(CFG_SPARE_HI, 9'h000);
        repeat (7) send_word(ir90_pkg::MODE_READ, 24'hffffff);
        drain();
    endtask

    // register extremes: zero and values past the maximum saturate; one long line
    // reaches the far end of a store row, only its first output rows are read back
    task automatic test_size_extremes();
        logic [ir90_pkg::CFG_DATA_W-1:0] dims [3][2];
        int unsigned                     n, reads;
        dims = '{'{9'd511, 9'd1}, '{9'd0, 9'd3}, '{9'd4, 9'd0}};
        for (int k = 0; k < 3; k++) begin
            no_stall = (k == 0);
            set_size(dims[k][0], dims[k][1]);
            n = clamp_dim(dims[k][0], ir90_pkg::MAX_WIDTH)
              * clamp_dim(dims[k][1], ir90_pkg::MAX_HEIGHT);
            reads = (k == 0) ? LINE_READS : n;
            repeat (n) send_word(ir90_pkg::MODE_LOAD, ir90_pkg::PIXEL_W'($urandom));
            repeat (reads) send_word(ir90_pkg::MODE_READ, ir90_pkg::PIXEL_W'($urandom));
            drain();
        end
        no_stall = 1'b0;
    endtask

    // mostly complete frames of random small sizes and random pixels, with noise:
    // early reads, loads into a full frame, reads past the end, and frames cut
    // short by a register write during loading or readout
    task automatic test_random_frames();
        int unsigned w, h, n, cut, frames_sent;
        int unsigned useful_words;
        bit          aborted;
        useful_words = 0;
        frames_sent  = 0;
        aborted      = 1'b1;
        while (useful_words < RANDOM_WORDS) begin
            no_stall = (frames_sent < 2);
            if (aborted || $urandom_range(0, 99) < 70) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
                set_size(ir90_pkg::CFG_DATA_W'(w), ir90_pkg::CFG_DATA_W'(h));
            end
            aborted = 1'b0;
            n = w * h;
            if ($urandom_range(0, 99) < 20)
                send_word(ir90_pkg::MODE_READ, ir90_pkg::PIXEL_W'($urandom));
            cut = n;
            if ($urandom_range(0, 99) < 8) begin
                cut     = $urandom_range(0, n - 1);
                aborted = 1'b1;
            end
            repeat (cut) begin
                if ($urandom_range(0, 99) < 8)
                    send_word(ir90_pkg::MODE_READ, ir90_pkg::PIXEL_W'($urandom));
                send_word(ir90_pkg::MODE_LOAD, ir90_pkg::PIXEL_W'($urandom));
            end
            if (!aborted) begin
                if ($urandom_range(0, 99) < 20)
                    send_word(ir90_pkg::MODE_LOAD, ir90_pkg::PIXEL_W'($urandom));
                if ($urandom_range(0, 99) < 8) begin
                    cut     = $urandom_range(0, n - 1);
                    aborted = 1'b1;
                end
                repeat (cut) send_word(ir90_pkg::MODE_READ, ir90_pkg::PIXEL_W'($urandom));
                if (!aborted && $urandom_range(0, 99) < 20)
                    send_word(ir90_pkg::MODE_READ, ir90_pkg::PIXEL_W'($urandom));
            end
            useful_words += 2 * n;
            frames_sent++;
            drain();
        end
        no_stall = 1'b0;
    endtask

    initial begin
        restart_positions();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_geometry();
        test_corner_pixels();
        test_size_extremes();
        test_random_frames();

        $display("tb: %0d result words checked, %0d rotated frames read out",
                 pixels_checked, frames_read);
        $display("tb: %0d register writes, sizes from 1x1 up to a saturated 256-pixel line",
                 reg_writes);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
